>>> design/assert_macros.svh
// =============================================================================
// assert_macros.svh
// Shared concurrent assertion macros for the date field parser checkers.
// =============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with asynchronous active-low reset disable.
`define ASSERT_CLKD(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> design/hdfp_pkg.sv
// =============================================================================
// hdfp_pkg
// Types, status codes and name tables shared by the date field parser.
// =============================================================================
package hdfp_pkg;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_LENGTH  = 3'd1,
    ST_WEEKDAY = 3'd2,
    ST_MONTH   = 3'd3,
    ST_FORMAT  = 3'd4,
    ST_ZONE    = 3'd5
  } status_e;

  // Fixed string length and the position of its final byte
  localparam logic [4:0] DATE_LEN = 5'd29;
  localparam logic [4:0] LAST_POS = 5'd28;

  localparam int unsigned NUM_WD = 7;
  localparam int unsigned NUM_MO = 12;

  localparam logic [7:0] WD_NAMES [NUM_WD][3] = '{
    '{"S", "u", "n"}, '{"M", "o", "n"}, '{"T", "u", "e"}, '{"W", "e", "d"},
    '{"T", "h", "u"}, '{"F", "r", "i"}, '{"S", "a", "t"}
  };

  localparam logic [7:0] MO_NAMES [NUM_MO][3] = '{
    '{"J", "a", "n"}, '{"F", "e", "b"}, '{"M", "a", "r"}, '{"A", "p", "r"},
    '{"M", "a", "y"}, '{"J", "u", "n"}, '{"J", "u", "l"}, '{"A", "u", "g"},
    '{"S", "e", "p"}, '{"O", "c", "t"}, '{"N", "o", "v"}, '{"D", "e", "c"}
  };

  localparam logic [7:0] ZONE_NAME [3] = '{"G", "M", "T"};

  localparam logic [7:0] COLON = ":";

  // One input request as held in the input register
  typedef struct packed {
    logic [7:0] chr;
    logic       last;
  } byte_t;

  // One parsed result
  typedef struct packed {
    status_e     status;
    logic [2:0]  weekday;
    logic [6:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } res_t;

  // acc * 10 + d, kept to 7 bits
  function automatic logic [6:0] mac7(input logic [6:0] acc, input logic [3:0] d);
    logic [9:0] s;
    s = {acc, 3'b000} + 10'({acc, 1'b0}) + 10'(d);
    return s[6:0];
  endfunction

  // acc * 10 + d, kept to 14 bits
  function automatic logic [13:0] mac14(input logic [13:0] acc, input logic [3:0] d);
    logic [16:0] s;
    s = {acc, 3'b000} + 17'({acc, 1'b0}) + 17'(d);
    return s[13:0];
  endfunction

endpackage

>>> design/hdfp_in_stage.sv
// =============================================================================
// hdfp_in_stage
// Input register: captures one byte request and releases it to the scanner.
// =============================================================================
module hdfp_in_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [7:0]           char_in_i,
  input  logic                 end_of_text_i,
  input  logic                 out_free_i,
  output logic                 adv_o,
  output hdfp_pkg::byte_t      byte_o
);

  logic            vld_q, vld_d;
  hdfp_pkg::byte_t byte_q;
  logic            load;

  // Advance a non-final byte always; a final byte needs room in the result slot
  assign adv_o      = vld_q && (!byte_q.last || out_free_i);
  assign in_stall_o = vld_q && !adv_o;
  assign load       = in_valid_i && !in_stall_o;
  assign byte_o     = byte_q;

  always_comb begin
    vld_d = vld_q;
    if (load) begin
      vld_d = 1'b1;
    end else if (adv_o) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Hold the payload unless a new request lands
  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q.chr  <= char_in_i;
      byte_q.last <= end_of_text_i;
    end
  end

endmodule

>>> design/hdfp_scan.sv
// =============================================================================
// hdfp_scan
// Per-byte matcher and accumulators; forms the result on the final byte.
// =============================================================================
module hdfp_scan (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  hdfp_pkg::byte_t byte_i,
  output hdfp_pkg::res_t  res_o
);

  logic [4:0]  pos_q;
  logic [6:0]  wd_q, wd_d;
  logic [11:0] mo_q, mo_d;
  logic        zone_q, zone_d;
  logic        fmt_q, fmt_d;
  logic        dbad_q, dbad_d;
  logic [6:0]  day_q, day_d;
  logic [13:0] year_q, year_d;
  logic [6:0]  hour_q, hour_d;
  logic [6:0]  min_q, min_d;
  logic [6:0]  sec_q, sec_d;

  logic [4:0]  pos_d;
  logic [4:0]  mo_off, zn_off;
  logic [1:0]  col_wd, col_mo, col_zn;
  logic        dig_ok;
  logic [3:0]  dval;
  logic [7:0]  chr;
  logic [2:0]  wd_idx;
  logic [3:0]  mo_idx;

  assign chr    = byte_i.chr;
  assign dig_ok = (chr >= "0") && (chr <= "9");
  assign dval   = chr[3:0];
  assign mo_off = pos_q - 5'd8;
  assign zn_off = pos_q - 5'd26;
  assign col_wd = pos_q[1:0];
  assign col_mo = mo_off[1:0];
  assign col_zn = zn_off[1:0];

  // Update matcher masks and accumulators for the byte at the current position
  always_comb begin
    wd_d   = wd_q;
    mo_d   = mo_q;
    zone_d = zone_q;
    fmt_d  = fmt_q;
    dbad_d = dbad_q;
    day_d  = day_q;
    year_d = year_q;
    hour_d = hour_q;
    min_d  = min_q;
    sec_d  = sec_q;
    if (pos_q < 5'd3) begin
      for (int i = 0; i < hdfp_pkg::NUM_WD; i++) begin
        if (hdfp_pkg::WD_NAMES[i][col_wd] != chr) wd_d[i] = 1'b0;
      end
    end else if (pos_q inside {5'd5, 5'd6}) begin
      if (dig_ok) day_d = hdfp_pkg::mac7(day_q, dval);
      else dbad_d = 1'b1;
    end else if (pos_q inside {[5'd8:5'd10]}) begin
      for (int i = 0; i < hdfp_pkg::NUM_MO; i++) begin
        if (hdfp_pkg::MO_NAMES[i][col_mo] != chr) mo_d[i] = 1'b0;
      end
    end else if (pos_q inside {[5'd12:5'd15]}) begin
      if (dig_ok) year_d = hdfp_pkg::mac14(year_q, dval);
      else fmt_d = 1'b1;
    end else if (pos_q inside {5'd17, 5'd18}) begin
      if (dig_ok) hour_d = hdfp_pkg::mac7(hour_q, dval);
      else fmt_d = 1'b1;
    end else if (pos_q inside {5'd19, 5'd22}) begin
      if (chr != hdfp_pkg::COLON) fmt_d = 1'b1;
    end else if (pos_q inside {5'd20, 5'd21}) begin
      if (dig_ok) min_d = hdfp_pkg::mac7(min_q, dval);
      else fmt_d = 1'b1;
    end else if (pos_q inside {5'd23, 5'd24}) begin
      if (dig_ok) sec_d = hdfp_pkg::mac7(sec_q, dval);
      else fmt_d = 1'b1;
    end else if (pos_q inside {[5'd26:5'd28]}) begin
      if (hdfp_pkg::ZONE_NAME[col_zn] != chr) zone_d = 1'b0;
    end
    pos_d = (pos_q < hdfp_pkg::DATE_LEN) ? pos_q + 5'd1 : pos_q;
  end

  // First surviving weekday and month
  always_comb begin
    wd_idx = '0;
    mo_idx = '0;
    for (int i = hdfp_pkg::NUM_WD - 1; i >= 0; i--) begin
      if (wd_d[i]) wd_idx = 3'(i);
    end
    for (int i = hdfp_pkg::NUM_MO - 1; i >= 0; i--) begin
      if (mo_d[i]) mo_idx = 4'(i);
    end
  end

  // Rank the faults and zero the fields of a failed parse
  always_comb begin
    res_o = '0;
    if (pos_q != hdfp_pkg::LAST_POS) begin
      res_o.status = hdfp_pkg::ST_LENGTH;
    end else if (wd_d == '0) begin
      res_o.status = hdfp_pkg::ST_WEEKDAY;
    end else if (dbad_d) begin
      res_o.status = hdfp_pkg::ST_FORMAT;
    end else if (mo_d == '0) begin
      res_o.status = hdfp_pkg::ST_MONTH;
    end else if (fmt_d || hour_d > 7'd23 || min_d > 7'd59 || sec_d > 7'd59) begin
      res_o.status = hdfp_pkg::ST_FORMAT;
    end else if (!zone_d) begin
      res_o.status = hdfp_pkg::ST_ZONE;
    end else begin
      res_o.status  = hdfp_pkg::ST_OK;
      res_o.weekday = wd_idx;
      res_o.day     = day_d;
      res_o.month   = mo_idx;
      res_o.year    = year_d;
      res_o.hour    = hour_d[4:0];
      res_o.minute  = min_d[5:0];
      res_o.second  = sec_d[5:0];
    end
  end

  // Advance the scan state; drop back to the start after the final byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      wd_q   <= '1;
      mo_q   <= '1;
      zone_q <= 1'b1;
      fmt_q  <= 1'b0;
      dbad_q <= 1'b0;
      day_q  <= '0;
      year_q <= '0;
      hour_q <= '0;
      min_q  <= '0;
      sec_q  <= '0;
    end else if (adv_i) begin
      if (byte_i.last) begin
        pos_q  <= '0;
        wd_q   <= '1;
        mo_q   <= '1;
        zone_q <= 1'b1;
        fmt_q  <= 1'b0;
        dbad_q <= 1'b0;
        day_q  <= '0;
        year_q <= '0;
        hour_q <= '0;
        min_q  <= '0;
        sec_q  <= '0;
      end else begin
        pos_q  <= pos_d;
        wd_q   <= wd_d;
        mo_q   <= mo_d;
        zone_q <= zone_d;
        fmt_q  <= fmt_d;
        dbad_q <= dbad_d;
        day_q  <= day_d;
        year_q <= year_d;
        hour_q <= hour_d;
        min_q  <= min_d;
        sec_q  <= sec_d;
      end
    end
  end

endmodule

>>> design/hdfp_out_stage.sv
// =============================================================================
// hdfp_out_stage
// Result register: holds one parsed result until the receiver takes it.
// =============================================================================
module hdfp_out_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  hdfp_pkg::res_t res_i,
  output logic           out_free_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output hdfp_pkg::res_t res_o
);

  logic           vld_q, vld_d;
  hdfp_pkg::res_t res_q;

  // Slot is free when empty or being taken this cycle
  assign out_free_o  = !vld_q || !out_stall_i;
  assign out_valid_o = vld_q;
  assign res_o       = res_q;

  always_comb begin
    vld_d = vld_q;
    if (load_i) begin
      vld_d = 1'b1;
    end else if (!out_stall_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Hold the result while stalled
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule

>>> design/http_date_field_parser.sv
// =============================================================================
// http_date_field_parser
// Byte-serial parser for fixed-form HTTP dates, "Www, DD Mmm YYYY hh:mm:ss GMT".
// =============================================================================
// Usage:
//   Input channel: one byte per request on char_in_i, end_of_text_i high on the
//   final byte. A request is taken on a clock edge with in_valid_i high and
//   in_stall_o low. Only the final byte of a string yields a result.
//   Output channel: status_o and the parsed fields, taken on an edge with
//   out_valid_o high and out_stall_i low. On any status other than ok every
//   field reads zero.
//   Path: a final byte is taken into the input register, then moves on into the
//   result register, where its result is shown (one input register, one result
//   register). Throughput: one byte per cycle while in_stall_o is low, set by the
//   combinational scan step between the two registers; bytes keep flowing while a
//   result waits. Stall: a held result blocks only a following final byte, which
//   then waits in the input register and raises in_stall_o.
//   Reset: both registers empty, scan state at the first byte of a string.
// =============================================================================
module http_date_field_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  char_in_i,
  input  logic        end_of_text_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [2:0]  weekday_o,
  output logic [6:0]  date_day_o,
  output logic [3:0]  month_index_o,
  output logic [13:0] year_value_o,
  output logic [4:0]  hour_value_o,
  output logic [5:0]  minute_value_o,
  output logic [5:0]  second_value_o
);

  logic            adv;
  logic            out_free;
  hdfp_pkg::byte_t byte_s;
  hdfp_pkg::res_t  res_s;
  hdfp_pkg::res_t  res_q;

  hdfp_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .char_in_i    (char_in_i),
    .end_of_text_i(end_of_text_i),
    .out_free_i   (out_free),
    .adv_o        (adv),
    .byte_o       (byte_s)
  );

  hdfp_scan u_scan (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .adv_i (adv),
    .byte_i(byte_s),
    .res_o (res_s)
  );

  hdfp_out_stage u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (adv && byte_s.last),
    .res_i      (res_s),
    .out_free_o (out_free),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .res_o      (res_q)
  );

  // Unpack the result onto the ports
  assign status_o       = res_q.status;
  assign weekday_o      = res_q.weekday;
  assign date_day_o     = res_q.day;
  assign month_index_o  = res_q.month;
  assign year_value_o   = res_q.year;
  assign hour_value_o   = res_q.hour;
  assign minute_value_o = res_q.minute;
  assign second_value_o = res_q.second;

endmodule

>>> design/hdfp_checker.sv
// =============================================================================
// hdfp_checker
// Port-level checks of the date field parser, bound to the top level.
// =============================================================================
`include "assert_macros.svh"

module hdfp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  status_o,
  input logic [2:0]  weekday_o,
  input logic [6:0]  date_day_o,
  input logic [3:0]  month_index_o,
  input logic [13:0] year_value_o,
  input logic [4:0]  hour_value_o,
  input logic [5:0]  minute_value_o,
  input logic [5:0]  second_value_o
);

  logic held;
  logic shown_ok;
  logic shown_fail;
  logic fields_zero;
  logic fields_in_range;

  // Classify the result on show
  assign held       = out_valid_o && out_stall_i;
  assign shown_ok   = out_valid_o && (status_o == hdfp_pkg::ST_OK);
  assign shown_fail = out_valid_o && (status_o != hdfp_pkg::ST_OK);
  assign fields_zero = (weekday_o == 3'd0) && (date_day_o == 7'd0) &&
                       (month_index_o == 4'd0) && (year_value_o == 14'd0) &&
                       (hour_value_o == 5'd0) && (minute_value_o == 6'd0) &&
                       (second_value_o == 6'd0);
  assign fields_in_range = (weekday_o <= 3'd6) && (month_index_o <= 4'd11) &&
                           (hour_value_o <= 5'd23) && (minute_value_o <= 6'd59) &&
                           (second_value_o <= 6'd59);

  // A stalled result keeps its status
  `ASSERT_CLKD(a_hold, clk_i, rst_ni, held |=> out_valid_o && $stable(status_o), "stall broken")

  // An empty result slot never stalls the input
  `ASSERT_IMPL(a_no_stall_empty, clk_i, rst_ni, !out_valid_o, !in_stall_o, "stall with empty slot")

  // A failed parse carries all-zero fields
  `ASSERT_IMPL(a_fail_zero, clk_i, rst_ni, shown_fail, fields_zero, "nonzero fields on failure")

  // A good parse has weekday, month and time fields within calendar ranges
  `ASSERT_IMPL(a_ok_range, clk_i, rst_ni, shown_ok, fields_in_range, "good parse out of range")

endmodule

bind http_date_field_parser hdfp_checker u_hdfp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .status_o      (status_o),
  .weekday_o     (weekday_o),
  .date_day_o    (date_day_o),
  .month_index_o (month_index_o),
  .year_value_o  (year_value_o),
  .hour_value_o  (hour_value_o),
  .minute_value_o(minute_value_o),
  .second_value_o(second_value_o)
);

>>> bench/tb_http_date_field_parser.sv
// -----------------------------------------------------------------------------
// tb_http_date_field_parser
// Self-checking bench for the byte-serial HTTP date parser. Date strings, both
// well formed and broken, are queued up front and fed one byte per request by
// a clocked driver. A predictor in the bench gives the result of every final
// byte, and a clocked monitor checks each result field by field.
// -----------------------------------------------------------------------------
module tb_http_date_field_parser;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned IDLE_PCT    = 17;

  // One byte request waiting to be driven; hold waits for all results first
  typedef struct {
    logic [7:0] chr;
    logic       last;
    bit         hold;
  } date_byte_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  char_in = 8'h00;
  logic        end_of_text = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  status;
  logic [2:0]  weekday;
  logic [6:0]  date_day;
  logic [3:0]  month_index;
  logic [13:0] year_value;
  logic [4:0]  hour_value;
  logic [5:0]  minute_value;
  logic [5:0]  second_value;

  date_byte_t      date_bytes[$];
  hdfp_pkg::res_t  due_dates[$];
  logic [7:0]      txt[$];
  int unsigned n_err = 0;
  int unsigned n_taken = 0;
  int unsigned n_seen = 0;
  int unsigned cycles = 0;
  wire         calm = (n_taken >= 500) && (n_taken < 800);

  // Parser prediction state
  logic [4:0]  pos_q;
  logic [6:0]  wd_hits;
  logic [11:0] mo_hits;
  logic        zone_good;
  logic        fmt_bad;
  logic        day_bad;
  logic [6:0]  day_acc;
  logic [13:0] year_acc;
  logic [6:0]  hour_acc;
  logic [6:0]  min_acc;
  logic [6:0]  sec_acc;

  http_date_field_parser u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .char_in_i      (char_in),
    .end_of_text_i  (end_of_text),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .status_o       (status),
    .weekday_o      (weekday),
    .date_day_o     (date_day),
    .month_index_o  (month_index),
    .year_value_o   (year_value),
    .hour_value_o   (hour_value),
    .minute_value_o (minute_value),
    .second_value_o (second_value)
  );

  // Clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic flag(input string what, input int got, input int want);
    $display("MISMATCH at %0t: %s got %0d want %0d", $time, what, got, want);
    n_err++;
  endtask

  function automatic bit is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  task automatic clear_parse();
    pos_q     = '0;
    wd_hits   = '1;
    mo_hits   = '1;
    zone_good = 1'b1;
    fmt_bad   = 1'b0;
    day_bad   = 1'b0;
    day_acc   = '0;
    year_acc  = '0;
    hour_acc  = '0;
    min_acc   = '0;
    sec_acc   = '0;
  endtask

  // Advance the prediction by one byte; queue a result on the final byte
  task automatic parse_byte(input logic [7:0] c, input logic last);
    logic [4:0]        p;
    hdfp_pkg::status_e st;
    hdfp_pkg::res_t    r;
    int                i;
    p = pos_q;
    if (p < 3) begin
      for (i = 0; i < hdfp_pkg::NUM_WD; i++)
        if (hdfp_pkg::WD_NAMES[i][p] != c) wd_hits[i] = 1'b0;
    end else if (p == 5 || p == 6) begin
      if (is_digit(c)) day_acc = 7'(day_acc * 10 + (c - "0"));
      else day_bad = 1'b1;
    end else if (p >= 8 && p <= 10) begin
      for (i = 0; i < hdfp_pkg::NUM_MO; i++)
        if (hdfp_pkg::MO_NAMES[i][p - 8] != c) mo_hits[i] = 1'b0;
    end else if (p >= 12 && p <= 15) begin
      if (is_digit(c)) year_acc = 14'(year_acc * 10 + (c - "0"));
      else fmt_bad = 1'b1;
    end else if (p == 17 || p == 18) begin
      if (is_digit(c)) hour_acc = 7'(hour_acc * 10 + (c - "0"));
      else fmt_bad = 1'b1;
    end else if (p == 19 || p == 22) begin
      if (c != hdfp_pkg::COLON) fmt_bad = 1'b1;
    end else if (p == 20 || p == 21) begin
      if (is_digit(c)) min_acc = 7'(min_acc * 10 + (c - "0"));
      else fmt_bad = 1'b1;
    end else if (p == 23 || p == 24) begin
      if (is_digit(c)) sec_acc = 7'(sec_acc * 10 + (c - "0"));
      else fmt_bad = 1'b1;
    end else if (p >= 26 && p <= 28) begin
      if (hdfp_pkg::ZONE_NAME[p - 26] != c) zone_good = 1'b0;
    end

    // Count bytes, saturating one past the final position
    if (pos_q < hdfp_pkg::DATE_LEN) pos_q = pos_q + 5'd1;

    if (last) begin
      if (p != hdfp_pkg::LAST_POS) st = hdfp_pkg::ST_LENGTH;
      else if (wd_hits == '0) st = hdfp_pkg::ST_WEEKDAY;
      else if (day_bad) st = hdfp_pkg::ST_FORMAT;
      else if (mo_hits == '0) st = hdfp_pkg::ST_MONTH;
      else if (fmt_bad || hour_acc > 23 || min_acc > 59 || sec_acc > 59)
        st = hdfp_pkg::ST_FORMAT;
      else if (!zone_good) st = hdfp_pkg::ST_ZONE;
      else st = hdfp_pkg::ST_OK;

      r = '0;
      r.status = st;
      if (st == hdfp_pkg::ST_OK) begin
        // Lowest matching name wins
        for (i = hdfp_pkg::NUM_WD - 1; i >= 0; i--)
          if (wd_hits[i]) r.weekday = 3'(i);
        for (i = hdfp_pkg::NUM_MO - 1; i >= 0; i--)
          if (mo_hits[i]) r.month = 4'(i);
        r.day    = day_acc;
        r.year   = year_acc;
        r.hour   = hour_acc[4:0];
        r.minute = min_acc[5:0];
        r.second = sec_acc[5:0];
      end
      due_dates.push_back(r);
      clear_parse();
    end
  endtask

  // Append a decimal number of n digits to the text buffer
  task automatic put_num(input int v, input int n);
    int k;
    for (k = n - 1; k >= 0; k--) txt.push_back(8'("0" + (v / (10 ** k)) % 10));
  endtask

  task automatic build_date(input int wd, input int dd, input int mo, input int yr,
                            input int hh, input int mi, input int ss);
    int k;
    txt = {};
    for (k = 0; k < 3; k++) txt.push_back(hdfp_pkg::WD_NAMES[wd][k]);
    txt.push_back(",");
    txt.push_back(" ");
    put_num(dd, 2);
    txt.push_back(" ");
    for (k = 0; k < 3; k++) txt.push_back(hdfp_pkg::MO_NAMES[mo][k]);
    txt.push_back(" ");
    put_num(yr, 4);
    txt.push_back(" ");
    put_num(hh, 2);
    txt.push_back(hdfp_pkg::COLON);
    put_num(mi, 2);
    txt.push_back(hdfp_pkg::COLON);
    put_num(ss, 2);
    txt.push_back(" ");
    for (k = 0; k < 3; k++) txt.push_back(hdfp_pkg::ZONE_NAME[k]);
  endtask

  // Mostly in-range time fields, with some out-of-range ones
  task automatic random_date();
    int hh, mi, ss;
    hh = ($urandom_range(99) < 85) ? $urandom_range(23) : $urandom_range(99);
    mi = ($urandom_range(99) < 85) ? $urandom_range(59) : $urandom_range(99);
    ss = ($urandom_range(99) < 85) ? $urandom_range(59) : $urandom_range(99);
    build_date($urandom_range(hdfp_pkg::NUM_WD - 1), $urandom_range(99),
               $urandom_range(hdfp_pkg::NUM_MO - 1), $urandom_range(9999), hh, mi, ss);
  endtask

  // Queue the text buffer as one string of byte requests
  task automatic send_text(input bit hold);
    date_byte_t b;
    int k;
    for (k = 0; k < txt.size(); k++) begin
      b.chr  = txt[k];
      b.last = (k == txt.size() - 1);
      b.hold = hold && (k == 0);
      date_bytes.push_back(b);
    end
  endtask

  // Record accepted requests and predict their results
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      parse_byte(char_in, end_of_text);
      n_taken++;
    end
  end

  // Drive the next request, or idle; hold a stalled request unchanged
  always @(negedge clk) begin : drive
    date_byte_t nxt;
    if (!in_valid || n_seen != n_taken) begin
      if (rst_n && date_bytes.size() != 0 &&
          !(date_bytes[0].hold && due_dates.size() != 0) &&
          (calm || $urandom_range(99) >= IDLE_PCT)) begin
        nxt = date_bytes.pop_front();
        in_valid    <= 1'b1;
        char_in     <= nxt.chr;
        end_of_text <= nxt.last;
      end else begin
        in_valid    <= 1'b0;
        char_in     <= 8'($urandom);
        end_of_text <= 1'($urandom);
      end
    end
    n_seen = n_taken;
    out_stall <= rst_n && !calm && ($urandom_range(99) < IDLE_PCT);
  end

  // Check each accepted result against the oldest one due
  always @(posedge clk) begin : check
    hdfp_pkg::res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (due_dates.size() == 0) begin
        flag("result with nothing due, status", status, -1);
      end else begin
        want = due_dates.pop_front();
        if (status != want.status)       flag("status", status, want.status);
        if (weekday != want.weekday)     flag("weekday", weekday, want.weekday);
        if (date_day != want.day)        flag("date_day", date_day, want.day);
        if (month_index != want.month)   flag("month_index", month_index, want.month);
        if (year_value != want.year)     flag("year_value", year_value, want.year);
        if (hour_value != want.hour)     flag("hour_value", hour_value, want.hour);
        if (minute_value != want.minute) flag("minute_value", minute_value, want.minute);
        if (second_value != want.second) flag("second_value", second_value, want.second);
      end
    end
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_http_date_field_parser: done, errors");
      $finish;
    end
  end

  initial begin
    int i, r, k;
    clear_parse();

    // Every weekday and month name, random fields
    for (i = 0; i < hdfp_pkg::NUM_MO; i++) begin
      build_date(i % hdfp_pkg::NUM_WD, $urandom_range(99), i, $urandom_range(9999),
                 $urandom_range(23), $urandom_range(59), $urandom_range(59));
      send_text(1'b0);
    end
    // Field extremes; wait for all results before the first
    build_date(0, 0, 0, 0, 0, 0, 0);
    send_text(1'b1);
    build_date(6, 99, 11, 9999, 23, 59, 59);
    send_text(1'b0);
    // Weekday and month case sensitive
    build_date(0, 1, 0, 2000, 1, 1, 1);
    txt[0] = "s";
    send_text(1'b0);
    build_date(1, 2, 0, 2001, 2, 2, 2);
    txt[8] = "j";
    send_text(1'b0);
    // Day digit fault ranks above an unknown month
    build_date(2, 3, 1, 2002, 3, 3, 3);
    txt[6] = "x";
    txt[9] = "X";
    send_text(1'b0);
    // Unknown month ranks above a year digit fault
    build_date(3, 4, 2, 2003, 4, 4, 4);
    txt[10] = "Q";
    txt[13] = "/";
    send_text(1'b0);
    // Bad colon, then time fields just out of range
    build_date(4, 5, 3, 2004, 5, 5, 5);
    txt[19] = ";";
    send_text(1'b0);
    build_date(5, 6, 4, 2005, 24, 0, 0);
    send_text(1'b0);
    build_date(6, 7, 5, 2006, 0, 60, 0);
    send_text(1'b0);
    build_date(0, 8, 6, 2007, 0, 0, 60);
    send_text(1'b0);
    // Zone not GMT, alone and under weekday and format faults
    build_date(1, 9, 7, 2008, 6, 6, 6);
    txt[26] = "U";
    txt[27] = "T";
    txt[28] = "C";
    send_text(1'b0);
    txt[1] = "U";
    send_text(1'b0);
    build_date(2, 10, 8, 2009, 30, 6, 6);
    txt[28] = "t";
    send_text(1'b0);
    // Length faults: one byte short, one long, one past the saturating byte counter, three bytes, a single byte
    build_date(3, 11, 9, 2010, 7, 7, 7);
    void'(txt.pop_back());
    send_text(1'b0);
    build_date(4, 12, 10, 2011, 8, 8, 8);
    txt.push_back(" ");
    send_text(1'b0);
    build_date(5, 13, 11, 2012, 9, 9, 9);
    for (k = 0; k < 32; k++) txt.push_back(txt[k % 29]);
    send_text(1'b0);
    txt = {8'h00, 8'hFF, 8'hFF};
    send_text(1'b0);
    txt = {8'hFF};
    send_text(1'b0);

    // Random strings: mostly well formed, some damaged, some noise
    while (date_bytes.size() < 1000) begin
      r = $urandom_range(99);
      random_date();
      if (r >= 55 && r < 75) begin
        k = $urandom_range(28);
        if ($urandom_range(1)) txt[k] = txt[k] ^ (8'h01 << $urandom_range(7));
        else txt[k] = 8'($urandom);
      end else if (r >= 75 && r < 85) begin
        if ($urandom_range(1)) begin
          k = $urandom_range(28, 1);
          while (txt.size() > k) void'(txt.pop_back());
        end else begin
          k = $urandom_range(40, 1);
          repeat (k) txt.push_back(8'($urandom));
        end
      end else if (r >= 85) begin
        txt = {};
        k = $urandom_range(35, 1);
        repeat (k) txt.push_back(8'($urandom));
      end
      send_text($urandom_range(19) == 0);
    end

    // Release reset and let the driver run
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    while (date_bytes.size() != 0 || in_valid || due_dates.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (n_err == 0) begin
      $display("tb_http_date_field_parser: done, clean");
    end else begin
      $display("tb_http_date_field_parser: done, errors");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+design
design/hdfp_pkg.sv
design/hdfp_in_stage.sv
design/hdfp_scan.sv
design/hdfp_out_stage.sv
design/http_date_field_parser.sv
design/hdfp_checker.sv
bench/tb_http_date_field_parser.sv
